/* hdl/qvr_pkg.sv */
// qvr_pkg: shared types and widths for the quaternion vector rotate unit
// depends on nothing; used by every module under hdl
`default_nettype none

package qvr_pkg;

    // field width of every input and output component
    localparam int FIELD_W = 16;
    // first product q*(0,v): sum of three 32-bit products, held in 34 bits
    localparam int T_W     = 34;
    // second-stage products: 34 x 16 bits
    localparam int RP_W    = T_W + FIELD_W;
    // second product: sum of four 50-bit products, held in 52 bits
    localparam int R_W     = RP_W + 2;

    // input beat
    typedef struct packed {
        logic signed [FIELD_W-1:0] vec_x;
        logic signed [FIELD_W-1:0] vec_y;
        logic signed [FIELD_W-1:0] vec_z;
        logic signed [FIELD_W-1:0] quat_w;
        logic signed [FIELD_W-1:0] quat_x;
        logic signed [FIELD_W-1:0] quat_y;
        logic signed [FIELD_W-1:0] quat_z;
    } operand_t;

    // result beat
    typedef struct packed {
        logic signed [FIELD_W-1:0] rot_x;
        logic signed [FIELD_W-1:0] rot_y;
        logic signed [FIELD_W-1:0] rot_z;
        logic                      clipped;
    } result_t;

    // quaternion carried down the pipe
    typedef struct packed {
        logic signed [FIELD_W-1:0] w;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
    } quat_t;

    // exact q*(0,v)
    typedef struct packed {
        logic signed [T_W-1:0] w;
        logic signed [T_W-1:0] x;
        logic signed [T_W-1:0] y;
        logic signed [T_W-1:0] z;
    } tvec_t;

    // exact vector part of q*(0,v)*conj(q)
    typedef struct packed {
        logic signed [R_W-1:0] x;
        logic signed [R_W-1:0] y;
        logic signed [R_W-1:0] z;
    } rvec_t;

    // bundle between the left and right multiply sections
    typedef struct packed {
        tvec_t t;
        quat_t q;
    } left_out_t;

endpackage

`default_nettype wire

/* hdl/quaternion_vector_rotate_unit.sv */
// quaternion_vector_rotate_unit: top level of the quaternion vector rotate pipeline
// depends on qvr_pkg, qvr_left_mul, qvr_right_mul, qvr_scale_sat
//
// Rotates a signed 16-bit vector by a signed fixed-point quaternion (QUAT_FRAC_BITS
// fractional bits): vector part of q*(0,v)*conj(q), exact, scaled down by
// 2^(2*QUAT_FRAC_BITS) toward zero and clamped to int16, clipped set on any clamp.
// Input channel: operand is taken at a clock edge where start is high and busy is
// low. busy is held low, so a beat can be given every cycle.
// Result channel: done is high for one cycle with result valid in that cycle; the
// receiver takes it at the edge that ends the cycle and cannot hold it off.
// Stages: two for q*(0,v), two for the product with conj(q), one scale/clamp stage.
// Throughput: one beat per cycle, set by the fully pipelined multiplier stages.
// Reset clears only the valid bits; no result is produced for beats in flight.
`default_nettype none

module quaternion_vector_rotate_unit #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire qvr_pkg::operand_t operand,
    output logic                   done,
    output qvr_pkg::result_t       result
);

    logic               left_valid;
    qvr_pkg::left_out_t left_data;
    logic               right_valid;
    qvr_pkg::rvec_t     right_data;

    // pipeline never stalls
    assign busy = 1'b0;

    // q * (0, v)
    qvr_left_mul u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .operand   (operand),
        .out_valid (left_valid),
        .out_data  (left_data)
    );

    // times conj(q)
    qvr_right_mul u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (left_valid),
        .in_data   (left_data),
        .out_valid (right_valid),
        .out_data  (right_data)
    );

    // scale and clamp
    qvr_scale_sat #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (right_valid),
        .in_data   (right_data),
        .out_valid (done),
        .out_data  (result)
    );

endmodule

`default_nettype wire

/* hdl/qvr_left_mul.sv */
// qvr_left_mul: two stages forming t = q * (0, v) exactly
// depends on qvr_pkg
`default_nettype none

module qvr_left_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire qvr_pkg::operand_t operand,
    output logic                   out_valid,
    output qvr_pkg::left_out_t     out_data
);

    // width of one 16 x 16 partial product
    localparam int P_W = 2 * qvr_pkg::FIELD_W;

    logic signed [P_W-1:0] prod_reg  [12];
    logic signed [P_W-1:0] prod_next [12];
    qvr_pkg::quat_t     q1_reg, q1_next;
    logic               v1_reg;
    qvr_pkg::left_out_t s2_reg, s2_next;
    logic               v2_reg;

    logic signed [qvr_pkg::FIELD_W-1:0] vx, vy, vz, qw, qx, qy, qz;

    assign vx = operand.vec_x;
    assign vy = operand.vec_y;
    assign vz = operand.vec_z;
    assign qw = operand.quat_w;
    assign qx = operand.quat_x;
    assign qy = operand.quat_y;
    assign qz = operand.quat_z;

    // stage 1: the twelve partial products
    always_comb
    begin
        prod_next[0]  = P_W'(qx) * P_W'(vx);
        prod_next[1]  = P_W'(qy) * P_W'(vy);
        prod_next[2]  = P_W'(qz) * P_W'(vz);
        prod_next[3]  = P_W'(qw) * P_W'(vx);
        prod_next[4]  = P_W'(qy) * P_W'(vz);
        prod_next[5]  = P_W'(qz) * P_W'(vy);
        prod_next[6]  = P_W'(qw) * P_W'(vy);
        prod_next[7]  = P_W'(qx) * P_W'(vz);
        prod_next[8]  = P_W'(qz) * P_W'(vx);
        prod_next[9]  = P_W'(qw) * P_W'(vz);
        prod_next[10] = P_W'(qx) * P_W'(vy);
        prod_next[11] = P_W'(qy) * P_W'(vx);
        q1_next.w = qw;
        q1_next.x = qx;
        q1_next.y = qy;
        q1_next.z = qz;
    end

    // stage 2: sums of the products
    always_comb
    begin
        s2_next.t.w = -qvr_pkg::T_W'(prod_reg[0]) - qvr_pkg::T_W'(prod_reg[1])
                      - qvr_pkg::T_W'(prod_reg[2]);
        s2_next.t.x =  qvr_pkg::T_W'(prod_reg[3]) + qvr_pkg::T_W'(prod_reg[4])
                      - qvr_pkg::T_W'(prod_reg[5]);
        s2_next.t.y =  qvr_pkg::T_W'(prod_reg[6]) - qvr_pkg::T_W'(prod_reg[7])
                      + qvr_pkg::T_W'(prod_reg[8]);
        s2_next.t.z =  qvr_pkg::T_W'(prod_reg[9]) + qvr_pkg::T_W'(prod_reg[10])
                      - qvr_pkg::T_W'(prod_reg[11]);
        s2_next.q   = q1_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 12; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
        q1_reg <= q1_next;
        s2_reg <= s2_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

endmodule

`default_nettype wire

/* hdl/qvr_right_mul.sv */
// qvr_right_mul: two stages forming the vector part of t * conj(q) exactly
// depends on qvr_pkg
`default_nettype none

module qvr_right_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire qvr_pkg::left_out_t in_data,
    output logic                    out_valid,
    output qvr_pkg::rvec_t          out_data
);

    logic signed [qvr_pkg::RP_W-1:0] prod_reg  [12];
    logic signed [qvr_pkg::RP_W-1:0] prod_next [12];
    logic           v3_reg;
    qvr_pkg::rvec_t r_reg, r_next;
    logic           v4_reg;

    logic signed [qvr_pkg::T_W-1:0]     tw, tx, ty, tz;
    logic signed [qvr_pkg::FIELD_W-1:0] qw, qx, qy, qz;

    assign tw = in_data.t.w;
    assign tx = in_data.t.x;
    assign ty = in_data.t.y;
    assign tz = in_data.t.z;
    assign qw = in_data.q.w;
    assign qx = in_data.q.x;
    assign qy = in_data.q.y;
    assign qz = in_data.q.z;

    // stage 3: products with the quaternion; conjugate signs go into the sums
    always_comb
    begin
        prod_next[0]  = qvr_pkg::RP_W'(tw) * qvr_pkg::RP_W'(qx);
        prod_next[1]  = qvr_pkg::RP_W'(tx) * qvr_pkg::RP_W'(qw);
        prod_next[2]  = qvr_pkg::RP_W'(ty) * qvr_pkg::RP_W'(qz);
        prod_next[3]  = qvr_pkg::RP_W'(tz) * qvr_pkg::RP_W'(qy);
        prod_next[4]  = qvr_pkg::RP_W'(tw) * qvr_pkg::RP_W'(qy);
        prod_next[5]  = qvr_pkg::RP_W'(tx) * qvr_pkg::RP_W'(qz);
        prod_next[6]  = qvr_pkg::RP_W'(ty) * qvr_pkg::RP_W'(qw);
        prod_next[7]  = qvr_pkg::RP_W'(tz) * qvr_pkg::RP_W'(qx);
        prod_next[8]  = qvr_pkg::RP_W'(tw) * qvr_pkg::RP_W'(qz);
        prod_next[9]  = qvr_pkg::RP_W'(tx) * qvr_pkg::RP_W'(qy);
        prod_next[10] = qvr_pkg::RP_W'(ty) * qvr_pkg::RP_W'(qx);
        prod_next[11] = qvr_pkg::RP_W'(tz) * qvr_pkg::RP_W'(qw);
    end

    // stage 4: vector part sums
    always_comb
    begin
        r_next.x = -qvr_pkg::R_W'(prod_reg[0]) + qvr_pkg::R_W'(prod_reg[1])
                   - qvr_pkg::R_W'(prod_reg[2]) + qvr_pkg::R_W'(prod_reg[3]);
        r_next.y = -qvr_pkg::R_W'(prod_reg[4]) + qvr_pkg::R_W'(prod_reg[5])
                   + qvr_pkg::R_W'(prod_reg[6]) - qvr_pkg::R_W'(prod_reg[7]);
        r_next.z = -qvr_pkg::R_W'(prod_reg[8]) - qvr_pkg::R_W'(prod_reg[9])
                   + qvr_pkg::R_W'(prod_reg[10]) + qvr_pkg::R_W'(prod_reg[11]);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 12; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
        r_reg <= r_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = r_reg;

endmodule

`default_nettype wire

/* hdl/qvr_scale_sat.sv */
// qvr_scale_sat: output stage, scales by 2^(2*QUAT_FRAC_BITS) toward zero and saturates
// depends on qvr_pkg
`default_nettype none

module qvr_scale_sat #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire qvr_pkg::rvec_t in_data,
    output logic                out_valid,
    output qvr_pkg::result_t    out_data
);

    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam logic signed [qvr_pkg::R_W-1:0] BIAS =
        (qvr_pkg::R_W'(1) << SHIFT) - qvr_pkg::R_W'(1);
    localparam logic signed [qvr_pkg::R_W-1:0] MAX16 = qvr_pkg::R_W'(32767);
    localparam logic signed [qvr_pkg::R_W-1:0] MIN16 = -qvr_pkg::R_W'(32768);

    logic signed [qvr_pkg::R_W-1:0]     comp    [3];
    logic signed [qvr_pkg::R_W-1:0]     biased  [3];
    logic signed [qvr_pkg::R_W-1:0]     shifted [3];
    logic signed [qvr_pkg::FIELD_W-1:0] sat     [3];
    logic        [2:0]                  clip;
    qvr_pkg::result_t                   res_reg, res_next;
    logic                               v5_reg;

    assign comp[0] = in_data.x;
    assign comp[1] = in_data.y;
    assign comp[2] = in_data.z;

    // truncate toward zero, then clamp each component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            biased[i]  = comp[i] + (comp[i][qvr_pkg::R_W-1] ? BIAS : '0);
            shifted[i] = biased[i] >>> SHIFT;
            if (shifted[i] > MAX16)
            begin
                sat[i]  = 16'sh7FFF;
                clip[i] = 1'b1;
            end
            else if (shifted[i] < MIN16)
            begin
                sat[i]  = 16'sh8000;
                clip[i] = 1'b1;
            end
            else
            begin
                sat[i]  = shifted[i][qvr_pkg::FIELD_W-1:0];
                clip[i] = 1'b0;
            end
        end
        res_next.rot_x   = sat[0];
        res_next.rot_y   = sat[1];
        res_next.rot_z   = sat[2];
        res_next.clipped = |clip;
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in_valid;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for quaternion_vector_rotate_unit, the q*(0,v)*conj(q) pipeline
// depends on qvr_pkg and the unit under hdl; directed table first, then random beats
// each accepted beat: typed expectation or 64-bit integer prediction, checked against done
module tb_top;

    localparam int FRAC_BITS = 14;

    // how a random component is drawn
    typedef enum int {
        DRAW_FULL,
        DRAW_WIDE,
        DRAW_UNIT,
        DRAW_TINY,
        DRAW_CORNER
    } draw_mode_e;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    qvr_pkg::operand_t operand;
    logic              done;
    qvr_pkg::result_t  result;

    // typed expectation that travels with a directed beat
    bit                row_typed;
    qvr_pkg::result_t  row_result;

    // expected rotations, oldest first
    qvr_pkg::result_t  expected_rot [$];
    int                mismatches;

    // directed table
    qvr_pkg::operand_t table_op [$];
    bit                table_typed [$];
    qvr_pkg::result_t  table_res [$];

    quaternion_vector_rotate_unit #(
        .QUAT_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .operand(operand),
        .done   (done),
        .result (result)
    );

    // clock, period 4
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // truncate toward zero by 2^(2*frac), then clamp to int16
    function automatic logic [15:0] scale_clamp(input longint raw, inout bit clip);
        longint scaled;
        scaled = raw / (longint'(1) << (2 * FRAC_BITS));
        if (scaled > 32767)
        begin
            scaled = 32767;
            clip = 1'b1;
        end
        else if (scaled < -32768)
        begin
            scaled = -32768;
            clip = 1'b1;
        end
        return scaled[15:0];
    endfunction

    // exact q*(0,v)*conj(q), vector part only
    function automatic qvr_pkg::result_t rotate_vector(input qvr_pkg::operand_t op);
        longint vx, vy, vz, qw, qx, qy, qz;
        longint tw, tx, ty, tz;
        longint rx, ry, rz;
        bit clip;
        qvr_pkg::result_t res;
        vx = longint'($signed(op.vec_x));
        vy = longint'($signed(op.vec_y));
        vz = longint'($signed(op.vec_z));
        qw = longint'($signed(op.quat_w));
        qx = longint'($signed(op.quat_x));
        qy = longint'($signed(op.quat_y));
        qz = longint'($signed(op.quat_z));
        // left product with the pure quaternion
        tw = -qx * vx - qy * vy - qz * vz;
        tx = qw * vx + qy * vz - qz * vy;
        ty = qw * vy - qx * vz + qz * vx;
        tz = qw * vz + qx * vy - qy * vx;
        // right product with the conjugate
        rx = -tw * qx + tx * qw - ty * qz + tz * qy;
        ry = -tw * qy + tx * qz + ty * qw - tz * qx;
        rz = -tw * qz - tx * qy + ty * qx + tz * qw;
        clip = 1'b0;
        res.rot_x = scale_clamp(rx, clip);
        res.rot_y = scale_clamp(ry, clip);
        res.rot_z = scale_clamp(rz, clip);
        res.clipped = clip;
        return res;
    endfunction

    function automatic logic [15:0] draw_component(input draw_mode_e mode);
        int corner [7] = '{-32768, -1, 0, 1, 16384, -16384, 32767};
        case (mode)
            DRAW_FULL:   return 16'($urandom);
            DRAW_WIDE:   return 16'(int'($urandom_range(0, 32768)) - 16384);
            DRAW_UNIT:   return 16'(int'($urandom_range(0, 18000)) - 9000);
            DRAW_TINY:   return 16'(int'($urandom_range(0, 128)) - 64);
            default:     return 16'(corner[$urandom_range(0, 6)]);
        endcase
    endfunction

    // mostly sane quaternions, some tiny, some at the corners
    function automatic qvr_pkg::operand_t random_operand();
        qvr_pkg::operand_t op;
        draw_mode_e qmode;
        draw_mode_e vmode;
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: qmode = DRAW_FULL;
            3, 4:    qmode = DRAW_WIDE;
            5, 6:    qmode = DRAW_UNIT;
            7:       qmode = DRAW_TINY;
            default: qmode = DRAW_CORNER;
        endcase
        vmode = (kind == 9) ? DRAW_CORNER : DRAW_FULL;
        op.vec_x  = draw_component(vmode);
        op.vec_y  = draw_component(vmode);
        op.vec_z  = draw_component(vmode);
        op.quat_w = draw_component(qmode);
        op.quat_x = draw_component(qmode);
        op.quat_y = draw_component(qmode);
        op.quat_z = draw_component(qmode);
        return op;
    endfunction

    task automatic add_row(input int vx, input int vy, input int vz,
                           input int qw, input int qx, input int qy, input int qz,
                           input bit typed = 1'b0, input int ex = 0, input int ey = 0,
                           input int ez = 0, input bit ec = 1'b0);
        qvr_pkg::operand_t op;
        qvr_pkg::result_t res;
        op.vec_x  = 16'(vx);
        op.vec_y  = 16'(vy);
        op.vec_z  = 16'(vz);
        op.quat_w = 16'(qw);
        op.quat_x = 16'(qx);
        op.quat_y = 16'(qy);
        op.quat_z = 16'(qz);
        res.rot_x = 16'(ex);
        res.rot_y = 16'(ey);
        res.rot_z = 16'(ez);
        res.clipped = ec;
        table_op.push_back(op);
        table_typed.push_back(typed);
        table_res.push_back(res);
    endtask

    // present one beat at the falling edge, with random idle cycles in front
    task automatic send_beat(input qvr_pkg::operand_t op, input bit typed,
                             input qvr_pkg::result_t res, input int idle_pct);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        operand    = op;
        row_typed  = typed;
        row_result = res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding rotation
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_rot.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    // record accepted beats and check done beats
    always @(posedge clk)
    begin
        qvr_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rot.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none got %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_rot.pop_front();
                    check_field("rot_x", want.rot_x, result.rot_x);
                    check_field("rot_y", want.rot_y, result.rot_y);
                    check_field("rot_z", want.rot_z, result.rot_z);
                    if (result.clipped !== want.clipped)
                    begin
                        $display("%0t: clipped expected %b got %b", $time, want.clipped,
                                 result.clipped);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_rot.push_back(row_typed ? row_result : rotate_vector(operand));
        end
    end

    // stimulus
    initial
    begin
        int idle_pct [3] = '{13, 63, 0};
        qvr_pkg::result_t no_res;
        mismatches = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operand    = '0;
        row_typed  = 1'b0;
        row_result = '0;
        no_res     = '0;

        // identity, zero quaternion and half turns about each axis
        add_row(100, -200, 300, 16384, 0, 0, 0, 1, 100, -200, 300, 0);
        add_row(32767, -32768, 0, 16384, 0, 0, 0, 1, 32767, -32768, 0, 0);
        add_row(1234, -4321, 77, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, -32768, -32768, -32768, -32768, 1, 0, 0, 0, 0);
        add_row(1, 2, 3, -16384, 0, 0, 0, 1, 1, 2, 3, 0);
        add_row(1, 2, 3, 0, 0, 0, 16384, 1, -1, -2, 3, 0);
        add_row(1, 2, 3, 0, 16384, 0, 0, 1, 1, -2, -3, 0);
        add_row(1, 2, 3, 0, 0, 16384, 0, 1, -1, 2, -3, 0);
        // negating the most negative value clamps
        add_row(-32768, -32768, -32768, 0, 0, 0, 16384, 1, 32767, 32767, -32768, 1);
        // non-unit quaternion scales by four
        add_row(10000, -10000, 1, -32768, 0, 0, 0, 1, 32767, -32768, 4, 1);
        // truncation toward zero, not toward minus infinity
        add_row(-5, 5, -32768, 1, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(-7, 7, -32768, 8192, 0, 0, 0, 1, -1, 1, -8192, 0);
        // everything else from the predictor
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_row(1000, -2000, 3000, 11585, 0, 0, 11585);
        add_row(-32768, 32767, -1, 32767, -32768, 32767, -32768);
        add_row(12345, -23456, 31000, 9459, -9459, 9459, -9459);
        add_row(-3, -3, -3, 3, -5, 7, -11);
        add_row(32767, -32768, 32767, 0, 0, 0, -32768);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_op[i])
            send_beat(table_op[i], table_typed[i], table_res[i], 0);
        drain_results();

        // three random phases: light idling, heavy idling, back to back
        for (int phase = 0; phase < 3; phase++)
        begin
            repeat (628)
                send_beat(random_operand(), 1'b0, no_res, idle_pct[phase]);
            drain_results();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hdl/qvr_pkg.sv
hdl/qvr_left_mul.sv
hdl/qvr_right_mul.sv
hdl/qvr_scale_sat.sv
hdl/quaternion_vector_rotate_unit.sv
tb/tb_top.sv
